// File: design/byte_stuffing_frame_encoder_unit_assert.svh
// ----------------------------------------------------------------------------
// byte_stuffing_frame_encoder_unit_assert.svh
// Assertion macros used by the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFING_FRAME_ENCODER_UNIT_ASSERT_SVH
`define BYTE_STUFFING_FRAME_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSFE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("encoder check failed");

// Next-cycle implication, checked outside reset.
`define BSFE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("encoder check failed");

`endif

// File: design/bsfe_pkg.sv
// ----------------------------------------------------------------------------
// bsfe_pkg
// Types and constants of the byte stuffing frame encoder.
// ----------------------------------------------------------------------------
package bsfe_pkg;

    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] ESC_BYTE    = 8'h7D;
    localparam logic [7:0] ESC_XOR     = 8'h20;
    localparam int         MAX_RESULTS = 7;
    localparam int         CNT_W       = $clog2(MAX_RESULTS + 1);

    // Input word: one raw payload byte with its frame marks
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_start;
        logic       frame_last;
    } in_word_t;

    // Output word: one encoded line byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } out_word_t;

    // All line bytes caused by one input word, first byte in entry 0
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
        logic                        ends_frame;
    } run_t;

    function automatic logic needs_escape(input logic [7:0] v);
        return (v == ESC_BYTE) || (v == FLAG_BYTE);
    endfunction

endpackage

// File: design/bsfe_expand.sv
// ----------------------------------------------------------------------------
// bsfe_expand
// Expands one input word into its escaped line bytes and next frame state.
// ----------------------------------------------------------------------------
module bsfe_expand (
    input  bsfe_pkg::in_word_t in_word,
    input  logic [7:0]         seq_cur,
    input  logic [7:0]         sum_cur,
    output bsfe_pkg::run_t     run,
    output logic [7:0]         seq_next,
    output logic [7:0]         sum_next
);
    import bsfe_pkg::*;

    logic [7:0]       sum_base;
    logic [7:0]       sum_data;
    logic [7:0]       chk;
    logic [3:0][7:0]  piece_val;
    logic [3:0]       piece_en;
    logic [3:0]       piece_esc;
    logic [CNT_W-1:0] pos;

    // Checksum: restart from the sequence byte on a frame start
    assign sum_base = in_word.frame_start ? seq_cur : sum_cur;
    assign sum_data = sum_base + in_word.payload_byte;
    assign chk      = ~sum_data;
    assign seq_next = in_word.frame_start ? seq_cur + 8'd1 : seq_cur;
    assign sum_next = in_word.frame_last ? 8'd0 : sum_data;

    // Pieces in line order: sequence, payload, checksum, end flag
    assign piece_val = {FLAG_BYTE, chk, in_word.payload_byte, seq_cur};
    assign piece_en  = {in_word.frame_last, in_word.frame_last, 1'b1, in_word.frame_start};
    assign piece_esc = {1'b0, needs_escape(chk), needs_escape(in_word.payload_byte),
                        needs_escape(seq_cur)};

    // Pack the enabled pieces, escape pairs taking two slots
    always_comb begin
        run.bytes      = '0;
        run.ends_frame = in_word.frame_last;
        pos            = '0;
        for (int i = 0; i < 4; i++) begin
            if (piece_en[i]) begin
                run.bytes[pos] = piece_esc[i] ? ESC_BYTE : piece_val[i];
                pos            = pos + CNT_W'(1);
                if (piece_esc[i]) begin
                    run.bytes[pos] = piece_val[i] ^ ESC_XOR;
                    pos            = pos + CNT_W'(1);
                end
            end
        end
        run.count = pos;
    end

endmodule

// File: design/byte_stuffing_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// byte_stuffing_frame_encoder_unit
// Byte stuffing frame encoder with sequence byte and additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_payload carry raw payload bytes with frame_start and
//   frame_last marks. m_valid/m_ready/m_payload carry encoded line bytes,
//   one per word. Each input word yields 1 to 7 line bytes: the sequence
//   byte on a frame start, the payload byte, and on a frame end the
//   inverted checksum and the 0x7E flag, each of the first three escaped.
//   run_last marks the last line byte caused by an input word.
//   An accepted word is registered in the holding register and then loaded
//   into the emit registers that drive the line side. The line side sends
//   one byte per cycle while m_ready is high. A one-word holding register
//   lets the next word be accepted while the current run drains.
//   Reset clears the sequence counter, the checksum and both valid flags.
//   When the receiver stalls (m_ready low) the current line byte holds;
//   once the holding register is full s_ready drops until the run ends.
// ----------------------------------------------------------------------------
`include "byte_stuffing_frame_encoder_unit_assert.svh"

module byte_stuffing_frame_encoder_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bsfe_pkg::in_word_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output bsfe_pkg::out_word_t m_payload
);
    import bsfe_pkg::*;

    logic [7:0]       seq_reg, seq_next;
    logic [7:0]       sum_reg, sum_next;
    run_t             exp_run;
    logic [7:0]       exp_seq, exp_sum;

    logic             pend_valid_reg, pend_valid_next;
    run_t             pend_run_reg, pend_run_next;

    logic             emit_valid_reg, emit_valid_next;
    logic [MAX_RESULTS-1:0][7:0] emit_bytes_reg, emit_bytes_next;
    logic [CNT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic             emit_end_reg, emit_end_next;

    logic             s_accept;
    logic             emit_pop;
    logic             emit_done;
    logic             pend_move;

    bsfe_expand u_expand (
        .in_word  (s_payload),
        .seq_cur  (seq_reg),
        .sum_cur  (sum_reg),
        .run      (exp_run),
        .seq_next (exp_seq),
        .sum_next (exp_sum)
    );

    // Handshake control
    assign emit_pop  = emit_valid_reg && m_ready;
    assign emit_done = emit_pop && (emit_cnt_reg == CNT_W'(1));
    assign pend_move = pend_valid_reg && (!emit_valid_reg || emit_done);
    assign s_ready   = !pend_valid_reg || pend_move;
    assign s_accept  = s_valid && s_ready;

    // Advance frame state on each accepted word
    always_comb begin
        seq_next = s_accept ? exp_seq : seq_reg;
        sum_next = s_accept ? exp_sum : sum_reg;
    end

    // Hold the expanded run until the line side is free
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_run_next   = pend_run_reg;
        if (pend_move) begin
            pend_valid_next = 1'b0;
        end
        if (s_accept) begin
            pend_valid_next = 1'b1;
            pend_run_next   = exp_run;
        end
    end

    // Load a new run or shift out the byte just taken
    always_comb begin
        emit_valid_next = emit_valid_reg;
        emit_bytes_next = emit_bytes_reg;
        emit_cnt_next   = emit_cnt_reg;
        emit_end_next   = emit_end_reg;
        if (pend_move) begin
            emit_valid_next = 1'b1;
            emit_bytes_next = pend_run_reg.bytes;
            emit_cnt_next   = pend_run_reg.count;
            emit_end_next   = pend_run_reg.ends_frame;
        end else if (emit_pop) begin
            emit_valid_next = !emit_done;
            emit_bytes_next = emit_bytes_reg >> 8;
            emit_cnt_next   = emit_cnt_reg - CNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= '0;
            sum_reg        <= '0;
            pend_valid_reg <= 1'b0;
            emit_valid_reg <= 1'b0;
        end else begin
            seq_reg        <= seq_next;
            sum_reg        <= sum_next;
            pend_valid_reg <= pend_valid_next;
            emit_valid_reg <= emit_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_run_reg   <= pend_run_next;
        emit_bytes_reg <= emit_bytes_next;
        emit_cnt_reg   <= emit_cnt_next;
        emit_end_reg   <= emit_end_next;
    end

    // Drive the line side from the head of the run
    assign m_valid             = emit_valid_reg;
    assign m_payload.out_byte  = emit_bytes_reg[0];
    assign m_payload.run_last  = (emit_cnt_reg == CNT_W'(1));
    assign m_payload.frame_end = emit_end_reg && (emit_cnt_reg == CNT_W'(1));

    // Checks
    `BSFE_ASSERT_IMP(a_emit_cnt_live, aclk, aresetn, emit_valid_reg,
        (emit_cnt_reg != '0) && (emit_cnt_reg <= CNT_W'(MAX_RESULTS)))
    `BSFE_ASSERT_IMP(a_end_is_flag, aclk, aresetn, m_valid && m_payload.frame_end,
        (m_payload.out_byte == FLAG_BYTE) && m_payload.run_last)
    `BSFE_ASSERT_NXT(a_accept_held, aclk, aresetn, s_accept, pend_valid_reg)
    `BSFE_ASSERT_NXT(a_move_fills, aclk, aresetn, pend_move, emit_valid_reg)

endmodule

// File: dv/bsfe_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_line_checker
// Watches both channels of the frame encoder, works out the line bytes that
// every accepted input word must produce and compares each line word that
// leaves the block against the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module bsfe_line_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  bsfe_pkg::in_word_t  s_payload,
    input  logic                m_valid,
    input  logic                m_ready,
    input  bsfe_pkg::out_word_t m_payload,
    output int                  fault_count,
    output int                  outstanding
);
    import bsfe_pkg::*;

    out_word_t  line_bytes_q[$];
    out_word_t  run_buf[MAX_RESULTS];
    int         run_len;
    logic [7:0] frame_seq;
    logic [7:0] frame_sum;
    int         faults = 0;
    int         pending_n = 0;

    assign fault_count = faults;
    assign outstanding = pending_n;

    task automatic note_fault(input string what, input logic [7:0] got,
                              input logic [7:0] want);
        $display("%0t ns: line word mismatch on %s: got %02h, want %02h",
                 $time, what, got, want);
        faults++;
    endtask

    task automatic emit(input logic [7:0] b, input logic is_flag);
        run_buf[run_len].out_byte  = b;
        run_buf[run_len].run_last  = 1'b0;
        run_buf[run_len].frame_end = is_flag;
        run_len++;
    endtask

    // Stuff a byte that collides with the flag or escape code
    task automatic emit_escaped(input logic [7:0] b);
        if (b == ESC_BYTE || b == FLAG_BYTE) begin
            emit(ESC_BYTE, 1'b0);
            emit(b ^ ESC_XOR, 1'b0);
        end else begin
            emit(b, 1'b0);
        end
    endtask

    // Work out the line bytes caused by one input word and queue them
    task automatic encode_word(input in_word_t w);
        run_len = 0;
        if (w.frame_start) begin
            // restart the checksum from the sequence byte, even in an open frame
            frame_sum = frame_seq;
            emit_escaped(frame_seq);
            frame_seq = frame_seq + 8'd1;
        end
        frame_sum = frame_sum + w.payload_byte;
        emit_escaped(w.payload_byte);
        if (w.frame_last) begin
            emit_escaped(~frame_sum);
            emit(FLAG_BYTE, 1'b1);
            frame_sum = '0;
        end
        run_buf[run_len-1].run_last = 1'b1;
        for (int i = 0; i < run_len; i++) begin
            line_bytes_q.push_back(run_buf[i]);
        end
    endtask

    // Predict on accepted input words, compare on accepted line words
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            frame_seq = '0;
            frame_sum = '0;
            line_bytes_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                encode_word(s_payload);
            end
            if (m_valid && m_ready) begin
                if (line_bytes_q.size() == 0) begin
                    note_fault("unexpected word", m_payload.out_byte, 8'h00);
                end else begin
                    want = line_bytes_q.pop_front();
                    if (m_payload.out_byte !== want.out_byte) begin
                        note_fault("out_byte", m_payload.out_byte, want.out_byte);
                    end
                    if (m_payload.run_last !== want.run_last) begin
                        note_fault("run_last", {7'd0, m_payload.run_last},
                                   {7'd0, want.run_last});
                    end
                    if (m_payload.frame_end !== want.frame_end) begin
                        note_fault("frame_end", {7'd0, m_payload.frame_end},
                                   {7'd0, want.frame_end});
                    end
                end
            end
        end
        pending_n <= line_bytes_q.size();
    end

endmodule

// File: dv/tb_byte_stuffing_frame_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_stuffing_frame_encoder_unit
// Drives payload words with frame marks into the encoder, with random gaps on
// the input side and random stalls on the line side, and gives the verdict
// from the failure count of the line checker.
// ----------------------------------------------------------------------------
module tb_byte_stuffing_frame_encoder_unit;
    import bsfe_pkg::*;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_payload;
    int        fault_count;
    int        outstanding;

    // Idling switches for the sending and the receiving side
    logic      src_idle = 1'b1;
    logic      snk_idle = 1'b1;
    // Frames opened so far, used to steer checksums onto escaped values
    logic [7:0] seq_guess = '0;

    byte_stuffing_frame_encoder_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    bsfe_line_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload),
        .fault_count (fault_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input logic [7:0] b, input logic st, input logic la);
        int gap;
        gap = src_idle ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= '{payload_byte: b, frame_start: st, frame_last: la};
        if (st) seq_guess = seq_guess + 8'd1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and hold off until every line byte has left the block
    task automatic drain_line;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Bias towards the two codes that need stuffing
    function automatic logic [7:0] pick_byte;
        logic [7:0] b;
        if ($urandom_range(0, 99) < 25) begin
            b = $urandom_range(0, 1) ? ESC_BYTE : FLAG_BYTE;
        end else begin
            b = $urandom_range(0, 255);
        end
        return b;
    endfunction

    // Line side: stall at random before each word
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = snk_idle ? $urandom_range(0, 13) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Stimulus and verdict
    initial begin
        int         kind;
        int         len;
        int         sent;
        logic [7:0] b;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, stuffing of payload bytes and checksums, frame corner cases
        send_word(8'h00, 1'b1, 1'b1);
        send_word(FLAG_BYTE, 1'b1, 1'b0);
        send_word(ESC_BYTE, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h5E, 1'b0, 1'b1);
        // words outside any frame
        send_word(ESC_BYTE, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        // restart inside an open frame
        send_word(8'h11, 1'b1, 1'b0);
        send_word(8'h22, 1'b1, 1'b0);
        send_word(8'hA5, 1'b0, 1'b1);
        // close with no open frame
        send_word(FLAG_BYTE, 1'b0, 1'b1);
        send_word(ESC_BYTE, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h5D, 1'b1, 1'b1);
        // checksums that come out as the flag and the escape code
        send_word(8'h81 - seq_guess, 1'b1, 1'b1);
        send_word(8'h82 - seq_guess, 1'b1, 1'b1);
        send_word(8'h40, 1'b1, 1'b0);
        send_word(8'h43 - seq_guess, 1'b0, 1'b1);
        drain_line;

        // Random: mostly well formed frames, some noise and broken frames
        for (int phase = 0; phase < 4; phase++) begin
            src_idle = (phase == 0) || (phase == 2);
            snk_idle = (phase == 0) || (phase == 3);
            sent = 0;
            while (sent < 40) begin
                kind = $urandom_range(0, 99);
                if (kind < 4) begin
                    // stray word
                    send_word(pick_byte(), 1'b0, 1'b0);
                    sent++;
                end else if (kind < 7) begin
                    // close without a start
                    send_word(pick_byte(), 1'b0, 1'b1);
                    sent++;
                end else if (kind < 10) begin
                    // abandoned frame, the next start drops it
                    send_word(pick_byte(), 1'b1, 1'b0);
                    send_word(pick_byte(), 1'b0, 1'b0);
                    sent += 2;
                end else begin
                    len = ($urandom_range(0, 99) < 75) ? 1 : $urandom_range(2, 4);
                    for (int i = 0; i < len; i++) begin
                        b = pick_byte();
                        if (len == 1 && $urandom_range(0, 99) < 15) begin
                            // steer the checksum onto a stuffed code
                            b = ($urandom_range(0, 1) ? 8'h81 : 8'h82) - seq_guess;
                        end
                        send_word(b, i == 0, i == len - 1);
                        sent++;
                    end
                end
            end
            drain_line;
        end

        if (fault_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/bsfe_pkg.sv
design/bsfe_expand.sv
design/byte_stuffing_frame_encoder_unit.sv
dv/bsfe_line_checker.sv
dv/tb_byte_stuffing_frame_encoder_unit.sv
